// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers shared by the RTL.
// ----------------------------------------------------------------------------
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define GAB_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define GAB_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

// ===== src/gab_pkg.sv =====
// ----------------------------------------------------------------------------
// gab_pkg
// Shared types and constants for the glyph alpha blitter.
// ----------------------------------------------------------------------------
`default_nettype none

package gab_pkg;

	localparam int MAX_SURFACE_DIM_DEF = 4096;
	localparam int MAX_GLYPH_DIM_DEF   = 255;

	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 24;
	localparam int CLIP_EDGE_W = 12;
	localparam int CLIP_SIZE_W = 13;
	localparam int CLIP_LEFT_MAX = (1 << CLIP_EDGE_W) - 1;
	localparam int COORD_W     = 18;
	localparam int ADDR_W      = 24;
	localparam int QUEUE_DEPTH = 4;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_FG_COLOR        = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CLIP_LEFT       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CLIP_TOP        = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_CLIP_WIDTH      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_CLIP_HEIGHT     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_SURFACE_STRIDE  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_BASELINE_ASCENT = 3'd6;

	// item kinds
	localparam logic FUNC_BEGIN    = 1'b0;
	localparam logic FUNC_COVERAGE = 1'b1;

	localparam logic [31:0] RB_MASK      = 32'h00FF00FF;
	localparam logic [31:0] G_MASK       = 32'h0000FF00;
	localparam logic [31:0] RB_ROUND     = 32'h00800080;
	localparam logic [31:0] G_ROUND      = 32'h00000080;
	localparam logic [31:0] RGB_MASK     = 32'h00FFFFFF;
	localparam logic [31:0] OPAQUE_ALPHA = 32'hFF000000;
	localparam logic [7:0]  COV_FULL     = 8'hFF;

	typedef struct packed {
		logic [23:0]            fg_color;
		logic [CLIP_EDGE_W-1:0] clip_left;
		logic [CLIP_EDGE_W-1:0] clip_top;
		logic [CLIP_SIZE_W-1:0] clip_width;
		logic [CLIP_SIZE_W-1:0] clip_height;
		logic [12:0]            surface_stride;
		logic [7:0]             baseline_ascent;
	} gab_cfg_t;

	localparam gab_cfg_t CFG_RESET = '{
		fg_color:        24'd0,
		clip_left:       12'd0,
		clip_top:        12'd0,
		clip_width:      13'd0,
		clip_height:     13'd0,
		surface_stride:  13'd640,
		baseline_ascent: 8'd0
	};

endpackage

`default_nettype wire

// ===== src/gab_front.sv =====
// ----------------------------------------------------------------------------
// gab_front
// Accepts begin and coverage beats, walks the glyph raster, clips, and
// queues the pixels that will be written.
// ----------------------------------------------------------------------------
`default_nettype none

module gab_front
	import gab_pkg::*;
#(
	parameter int MAX_SURFACE_DIM = MAX_SURFACE_DIM_DEF,
	parameter int MAX_GLYPH_DIM   = MAX_GLYPH_DIM_DEF,
	parameter int PX_W            = $clog2(CLIP_LEFT_MAX + MAX_SURFACE_DIM)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  gab_cfg_t            cfg,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                func,
	input  logic signed [15:0]  pen_x,
	input  logic signed [15:0]  pen_y,
	input  logic [7:0]          glyph_width,
	input  logic [7:0]          glyph_height,
	input  logic signed [7:0]   x_offset,
	input  logic signed [8:0]   y_offset,
	input  logic [7:0]          coverage,
	input  logic [31:0]         dest_pixel,
	output logic                push_valid,
	input  logic                push_ready,
	output logic [PX_W-1:0]     push_x,
	output logic [PX_W-1:0]     push_y,
	output logic [7:0]          push_coverage,
	output logic [31:0]         push_dest
);

	localparam int GDIM_W = $clog2(MAX_GLYPH_DIM + 1);
	localparam int CLIP_W = $clog2(MAX_SURFACE_DIM + 1);

	logic [COORD_W-1:0] origin_x_q, origin_y_q;
	logic [GDIM_W-1:0]  width_q, height_q, col_q, row_q;

	logic               accept, active, in_x, in_y;
	logic [COORD_W-1:0] px, py, lim_x, lim_y;
	logic [CLIP_W-1:0]  clip_w_sat, clip_h_sat;
	logic [GDIM_W-1:0]  width_sat, height_sat;

	assign in_ready = push_ready;
	assign accept   = in_valid && in_ready;
	assign active   = (width_q != '0) && (row_q < height_q);

	assign width_sat  = (32'(glyph_width) > 32'(MAX_GLYPH_DIM)) ?
		GDIM_W'(MAX_GLYPH_DIM) : GDIM_W'(glyph_width);
	assign height_sat = (32'(glyph_height) > 32'(MAX_GLYPH_DIM)) ?
		GDIM_W'(MAX_GLYPH_DIM) : GDIM_W'(glyph_height);

	assign clip_w_sat = (32'(cfg.clip_width) > 32'(MAX_SURFACE_DIM)) ?
		CLIP_W'(MAX_SURFACE_DIM) : CLIP_W'(cfg.clip_width);
	assign clip_h_sat = (32'(cfg.clip_height) > 32'(MAX_SURFACE_DIM)) ?
		CLIP_W'(MAX_SURFACE_DIM) : CLIP_W'(cfg.clip_height);

	assign px    = origin_x_q + COORD_W'(col_q);
	assign py    = origin_y_q + COORD_W'(row_q);
	assign lim_x = COORD_W'(cfg.clip_left) + COORD_W'(clip_w_sat);
	assign lim_y = COORD_W'(cfg.clip_top) + COORD_W'(clip_h_sat);

	// negative coordinates never pass since the clip edges are unsigned
	assign in_x = !px[COORD_W-1] && (px >= COORD_W'(cfg.clip_left)) && (px < lim_x);
	assign in_y = !py[COORD_W-1] && (py >= COORD_W'(cfg.clip_top)) && (py < lim_y);

	assign push_valid    = accept && (func == FUNC_COVERAGE) && active &&
		(coverage != 8'd0) && in_x && in_y;
	assign push_x        = PX_W'(px);
	assign push_y        = PX_W'(py);
	assign push_coverage = coverage;
	assign push_dest     = dest_pixel;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q <= '0;
			origin_y_q <= '0;
			width_q    <= '0;
			height_q   <= '0;
			col_q      <= '0;
			row_q      <= '0;
		end else if (accept) begin
			if (func == FUNC_BEGIN) begin
				origin_x_q <= COORD_W'(pen_x) + COORD_W'(x_offset);
				origin_y_q <= COORD_W'(pen_y) + COORD_W'(cfg.baseline_ascent) +
					COORD_W'(y_offset);
				width_q    <= width_sat;
				height_q   <= height_sat;
				col_q      <= '0;
				row_q      <= '0;
			end else if (active) begin
				if (col_q == width_q - 1'b1) begin
					col_q <= '0;
					row_q <= row_q + 1'b1;
				end else begin
					col_q <= col_q + 1'b1;
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== src/gab_queue.sv =====
// ----------------------------------------------------------------------------
// gab_queue
// Small register FIFO between the raster front and the blend back end.
// ----------------------------------------------------------------------------
`default_nettype none

module gab_queue
	import gab_pkg::*;
#(
	parameter int DATA_W = 8,
	parameter int DEPTH  = QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push_valid,
	output logic              push_ready,
	input  logic [DATA_W-1:0] push_data,
	output logic              pop_valid,
	input  logic              pop_ready,
	output logic [DATA_W-1:0] pop_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_push, do_pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== src/gab_back.sv =====
// ----------------------------------------------------------------------------
// gab_back
// Two-stage blend and address pipeline: products in the first stage,
// final pixel word and address in the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module gab_back
	import gab_pkg::*;
#(
	parameter int MAX_SURFACE_DIM = MAX_SURFACE_DIM_DEF,
	parameter int PX_W            = $clog2(CLIP_LEFT_MAX + MAX_SURFACE_DIM)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  gab_cfg_t          cfg,
	input  logic              pop_valid,
	output logic              pop_ready,
	input  logic [PX_W-1:0]   pop_x,
	input  logic [PX_W-1:0]   pop_y,
	input  logic [7:0]        pop_coverage,
	input  logic [31:0]       pop_dest,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [ADDR_W-1:0] pixel_address,
	output logic [31:0]       pixel_value
);

	localparam int STRIDE_W = $clog2(MAX_SURFACE_DIM + 1);
	localparam int PROD_W   = PX_W + STRIDE_W;

	logic [STRIDE_W-1:0] stride_sat;
	logic [31:0]         src;
	logic [7:0]          inv;
	logic                ready_s1, ready_s2;

	logic                valid_s1, opaque_s1;
	logic [31:0]         rb_s1, g_s1;
	logic [PROD_W-1:0]   row_base_s1;
	logic [PX_W-1:0]     x_s1;

	assign stride_sat = (32'(cfg.surface_stride) > 32'(MAX_SURFACE_DIM)) ?
		STRIDE_W'(MAX_SURFACE_DIM) : STRIDE_W'(cfg.surface_stride);
	assign src = 32'(cfg.fg_color) & RGB_MASK;
	assign inv = COV_FULL - pop_coverage;

	assign ready_s2  = !out_valid || out_ready;
	assign ready_s1  = !valid_s1 || ready_s2;
	assign pop_ready = ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (ready_s1) begin
				valid_s1 <= pop_valid;
			end
			if (ready_s2) begin
				out_valid <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && pop_valid) begin
			// per-channel sums stay below 2^16, so packed lanes never carry
			rb_s1       <= (src & RB_MASK) * 32'(pop_coverage) +
				(pop_dest & RB_MASK) * 32'(inv) + RB_ROUND;
			g_s1        <= (src & G_MASK) * 32'(pop_coverage) +
				(pop_dest & G_MASK) * 32'(inv) + G_ROUND;
			opaque_s1   <= (pop_coverage == COV_FULL);
			row_base_s1 <= PROD_W'(pop_y) * PROD_W'(stride_sat);
			x_s1        <= pop_x;
		end
		if (ready_s2 && valid_s1) begin
			pixel_value   <= opaque_s1 ? (src | OPAQUE_ALPHA) :
				(((rb_s1 >> 8) & RB_MASK) | ((g_s1 >> 8) & G_MASK));
			pixel_address <= ADDR_W'(row_base_s1) + ADDR_W'(x_s1);
		end
	end

endmodule

`default_nettype wire

// ===== src/glyph_alpha_blit.sv =====
// ----------------------------------------------------------------------------
// glyph_alpha_blit
// Blends one 8-bit coverage glyph into a 32-bit frame buffer, one pixel per
// beat, with clipping and address generation.
// ----------------------------------------------------------------------------
//  channel   handshake              payload
//  in        in_valid / in_ready    func, pen/glyph fields, coverage, dest_pixel
//  out       out_valid / out_ready  pixel_address, pixel_value
//  cfg       cfg_we                 cfg_index, cfg_wdata
//
//  One input beat per clock while in_ready is high. A drawn pixel is written
//  into the queue, then fills the product stage, then loads the output
//  register. Both back-end stages take one pixel per clock unless out_ready
//  stalls them; the 4-entry queue lets the front keep accepting while the
//  output is stalled, in_ready drops when full.
//  Reset clears raster state and the queue; stride comes up as 640.
// ----------------------------------------------------------------------------
`default_nettype none

module glyph_alpha_blit
	import gab_pkg::*;
#(
	parameter int MAX_SURFACE_DIM = MAX_SURFACE_DIM_DEF,
	parameter int MAX_GLYPH_DIM   = MAX_GLYPH_DIM_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  func,
	input  logic signed [15:0]    pen_x,
	input  logic signed [15:0]    pen_y,
	input  logic [7:0]            glyph_width,
	input  logic [7:0]            glyph_height,
	input  logic signed [7:0]     x_offset,
	input  logic signed [8:0]     y_offset,
	input  logic [7:0]            coverage,
	input  logic [31:0]           dest_pixel,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [ADDR_W-1:0]     pixel_address,
	output logic [31:0]           pixel_value
);

`include "assert_macros.svh"

	localparam int PX_W   = $clog2(CLIP_LEFT_MAX + MAX_SURFACE_DIM);
	localparam int ITEM_W = 2 * PX_W + 8 + 32;

	gab_cfg_t cfg_q;

	logic              push_valid, push_ready, pop_valid, pop_ready;
	logic [PX_W-1:0]   push_x, push_y, pop_x, pop_y;
	logic [7:0]        push_coverage, pop_coverage;
	logic [31:0]       push_dest, pop_dest;
	logic [ITEM_W-1:0] pop_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_FG_COLOR:        cfg_q.fg_color        <= cfg_wdata;
				CFG_CLIP_LEFT:       cfg_q.clip_left       <= cfg_wdata[CLIP_EDGE_W-1:0];
				CFG_CLIP_TOP:        cfg_q.clip_top        <= cfg_wdata[CLIP_EDGE_W-1:0];
				CFG_CLIP_WIDTH:      cfg_q.clip_width      <= cfg_wdata[CLIP_SIZE_W-1:0];
				CFG_CLIP_HEIGHT:     cfg_q.clip_height     <= cfg_wdata[CLIP_SIZE_W-1:0];
				CFG_SURFACE_STRIDE:  cfg_q.surface_stride  <= cfg_wdata[12:0];
				CFG_BASELINE_ASCENT: cfg_q.baseline_ascent <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	gab_front #(
		.MAX_SURFACE_DIM (MAX_SURFACE_DIM),
		.MAX_GLYPH_DIM   (MAX_GLYPH_DIM),
		.PX_W            (PX_W)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.func          (func),
		.pen_x         (pen_x),
		.pen_y         (pen_y),
		.glyph_width   (glyph_width),
		.glyph_height  (glyph_height),
		.x_offset      (x_offset),
		.y_offset      (y_offset),
		.coverage      (coverage),
		.dest_pixel    (dest_pixel),
		.push_valid    (push_valid),
		.push_ready    (push_ready),
		.push_x        (push_x),
		.push_y        (push_y),
		.push_coverage (push_coverage),
		.push_dest     (push_dest)
	);

	gab_queue #(
		.DATA_W (ITEM_W),
		.DEPTH  (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  ({push_x, push_y, push_coverage, push_dest}),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	assign {pop_x, pop_y, pop_coverage, pop_dest} = pop_data;

	gab_back #(
		.MAX_SURFACE_DIM (MAX_SURFACE_DIM),
		.PX_W            (PX_W)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.pop_valid     (pop_valid),
		.pop_ready     (pop_ready),
		.pop_x         (pop_x),
		.pop_y         (pop_y),
		.pop_coverage  (pop_coverage),
		.pop_dest      (pop_dest),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.pixel_address (pixel_address),
		.pixel_value   (pixel_value)
	);

	// a queued pixel always has room
	`GAB_ASSERT_IMPL(a_push_has_room, push_valid, push_ready)
	// begin beats never produce a pixel
	`GAB_ASSERT_IMPL(a_begin_no_push, in_valid && in_ready && (func == FUNC_BEGIN), !push_valid)
	// queue head is not dropped while the back end is stalled
	`GAB_ASSERT_NEXT(a_head_held, pop_valid && !pop_ready, pop_valid && $stable(pop_data))

endmodule

`default_nettype wire
